// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the accumulator RTL.
// Depends on nothing; files that check their logic include it by name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// A property that must hold at every clock edge out of reset.
`define QEFA_ASSERT(lbl, clk, rst_n, prop) \
lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
	else $error("check failed");
// An implication checked in the same cycle.
`define QEFA_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
	else $error("implication failed");
`else
`define QEFA_ASSERT(lbl, clk, rst_n, prop)
`define QEFA_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ===== rtl/qefa_pkg.sv =====
// Shared types and constants of the QEF plane accumulator.
// Depends on nothing; every module of the block imports it.
package qefa_pkg;

	localparam int DATA_W    = 32;
	localparam int ERR_W     = 63;
	localparam int CNT_W     = 16;
	localparam int ACC_WIDTH = 64;

	// Saturation limits of the running sums, in a 65-bit signed form.
	localparam logic signed [64:0] ACC_MAX_X = (65'sd1 <<< (ACC_WIDTH - 1)) - 65'sd1;
	localparam logic signed [64:0] ACC_MIN_X = -ACC_MAX_X - 65'sd1;
	localparam logic [ERR_W-1:0]   ERR_MAX   = {ERR_W{1'b1}};

	// Request opcodes.
	localparam logic [1:0] OP_ADD   = 2'd0;
	localparam logic [1:0] OP_EVAL  = 2'd1;
	localparam logic [1:0] OP_CLEAR = 2'd2;
	localparam logic [1:0] OP_NOP   = 2'd3;

	// Request queue between the front and the back.
	localparam int QDEPTH = 2;
	localparam int QPTR_W = $clog2(QDEPTH);

	// One classified request as it waits in the queue.
	typedef struct packed {
		logic [1:0]              op;
		logic [2:0][DATA_W-1:0]  pos;
		logic [2:0][DATA_W-1:0]  mag;
		logic [2:0]              neg;
		logic                    nz;
	} qefa_entry_t;

	// Queue status seen by both sides.
	typedef struct packed {
		logic empty;
		logic full;
	} qefa_qstat_t;

endpackage

// ===== rtl/qefa_front.sv =====
// Front end: request handshake and classification of each request.
// Depends on qefa_pkg; feeds qefa_queue.
module qefa_front import qefa_pkg::*; (
	input  logic                     start,
	output logic                     busy,
	input  logic [1:0]               opcode,
	input  logic signed [DATA_W-1:0] pos_x,
	input  logic signed [DATA_W-1:0] pos_y,
	input  logic signed [DATA_W-1:0] pos_z,
	input  logic signed [DATA_W-1:0] norm_x,
	input  logic signed [DATA_W-1:0] norm_y,
	input  logic signed [DATA_W-1:0] norm_z,
	input  qefa_qstat_t              qstat,
	output logic                     push,
	output qefa_entry_t              entry
);

	logic [2:0][DATA_W-1:0] nrm;

	// A request is taken whenever the queue has room.
	assign busy = qstat.full;
	assign push = start && !qstat.full;

	// Split the normal into sign and magnitude and flag a nonzero normal.
	always_comb begin
		nrm[0] = norm_x;
		nrm[1] = norm_y;
		nrm[2] = norm_z;
		entry.op  = opcode;
		entry.pos[0] = pos_x;
		entry.pos[1] = pos_y;
		entry.pos[2] = pos_z;
		for (int i = 0; i < 3; i++) begin
			entry.neg[i] = nrm[i][DATA_W-1];
			entry.mag[i] = nrm[i][DATA_W-1] ? (~nrm[i] + 1'b1) : nrm[i];
		end
		entry.nz = |(nrm[0] | nrm[1] | nrm[2]);
	end

endmodule

// ===== rtl/qefa_queue.sv =====
// Short request queue that decouples the front from the back.
// Depends on qefa_pkg and assert_macros.svh.
`include "assert_macros.svh"
module qefa_queue import qefa_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  qefa_entry_t wdata,
	input  logic        pop,
	output qefa_entry_t rdata,
	output qefa_qstat_t qstat
);

	qefa_entry_t       mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0]   fill_q;

	assign rdata       = mem_q[rd_ptr_q];
	assign qstat.empty = (fill_q == '0);
	assign qstat.full  = (fill_q == (QPTR_W+1)'(QDEPTH));

	// Entry storage needs no reset.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (pop && !push) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

	`QEFA_ASSERT_IMP(a_push_room, clk, arst_n, push, !qstat.full)
	`QEFA_ASSERT_IMP(a_pop_data, clk, arst_n, pop, !qstat.empty)
	`QEFA_ASSERT(a_fill_bound, clk, arst_n, fill_q <= (QPTR_W+1)'(QDEPTH))

endmodule

// ===== rtl/qefa_back.sv =====
// Back end: sequencer that carries out add, evaluate, clear and no-op requests.
// Depends on qefa_pkg and assert_macros.svh; pops qefa_queue.
`include "assert_macros.svh"
module qefa_back import qefa_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  qefa_qstat_t       qstat,
	input  qefa_entry_t       head,
	output logic              pop,
	output logic              done,
	output logic [ERR_W-1:0]  error_value,
	output logic [CNT_W-1:0]  sample_count,
	output logic              saturated
);

	// Sequencer states.
	localparam logic [4:0] S_IDLE = 5'd0;
	localparam logic [4:0] S_NORM = 5'd1;
	localparam logic [4:0] S_SQ   = 5'd2;
	localparam logic [4:0] S_SQRT = 5'd3;
	localparam logic [4:0] S_DLD  = 5'd4;
	localparam logic [4:0] S_DIV  = 5'd5;
	localparam logic [4:0] S_DOT  = 5'd6;
	localparam logic [4:0] S_RND  = 5'd7;
	localparam logic [4:0] S_SQD  = 5'd8;
	localparam logic [4:0] S_AT   = 5'd9;
	localparam logic [4:0] S_BT   = 5'd10;
	localparam logic [4:0] S_PT   = 5'd11;
	localparam logic [4:0] S_EOP  = 5'd12;
	localparam logic [4:0] S_WMUL = 5'd13;
	localparam logic [4:0] S_WF1  = 5'd14;
	localparam logic [4:0] S_WF2  = 5'd15;
	localparam logic [4:0] S_EFIN = 5'd16;

	// Layout of the sum registers: A, b, c, then positions.
	localparam int         NUM_SUMS = 13;
	localparam logic [3:0] IDX_B0   = 4'd6;
	localparam logic [3:0] IDX_C    = 4'd9;
	localparam logic [3:0] IDX_P0   = 4'd10;

	// Round half away from zero of v / 2^k.
	function automatic logic signed [63:0] rnd_shift(input logic signed [63:0] v,
		input int k);
		logic [63:0] mg;
		logic [63:0] rr;
		mg = v[63] ? (~v + 64'd1) : v;
		rr = (mg + (64'd1 << (k - 1))) >> k;
		return v[63] ? (~rr + 64'd1) : rr;
	endfunction

	// Saturating add; the top bit of the result flags saturation.
	function automatic logic [64:0] sat_add(input logic signed [63:0] a,
		input logic signed [63:0] b);
		logic signed [64:0] s;
		s = {a[63], a} + {b[63], b};
		if (s > ACC_MAX_X) begin
			return {1'b1, ACC_MAX_X[63:0]};
		end else if (s < ACC_MIN_X) begin
			return {1'b1, ACC_MIN_X[63:0]};
		end
		return {1'b0, s[63:0]};
	endfunction

	function automatic logic [63:0] mag64(input logic [63:0] v);
		return v[63] ? (~v + 64'd1) : v;
	endfunction

	// Row and column of the upper-triangle entry k of A.
	function automatic logic [1:0] pair_a(input logic [3:0] k);
		unique case (k) inside
			4'd0, 4'd1, 4'd2: return 2'd0;
			4'd3, 4'd4:       return 2'd1;
			default:          return 2'd2;
		endcase
	endfunction

	function automatic logic [1:0] pair_b(input logic [3:0] k);
		unique case (k) inside
			4'd0:             return 2'd0;
			4'd1, 4'd3:       return 2'd1;
			default:          return 2'd2;
		endcase
	endfunction

	logic [4:0]               state_q;
	logic [3:0]               idx_q;
	logic [1:0]               ph_q;
	logic [4:0]               it_q;
	logic [1:0]               pp_q;
	logic signed [31:0]       pos_q [3];
	logic [31:0]              mag_q [3];
	logic [2:0]               neg_q;
	logic signed [31:0]       u_q [3];
	logic [63:0]              sumsq_q;
	logic [63:0]              sq_res_q;
	logic [63:0]              sq_bit_q;
	logic [31:0]              root_q;
	logic [32:0]              rem_q;
	logic [30:0]              numlo_q;
	logic [30:0]              quo_q;
	logic signed [63:0]       dacc_q;
	logic signed [33:0]       dot_q;
	logic signed [63:0]       term_q;
	logic signed [67:0]       prod_q;
	logic signed [63:0]       sums_q [NUM_SUMS];
	logic [CNT_W-1:0]         cnt_q;
	logic                     sat_q;
	logic [127:0]             acc_q;
	logic [127:0]             wprod_q;
	logic [127:0]             wterm_q;
	logic [63:0]              ma_q;
	logic [63:0]              mb_q;
	logic                     wneg_q;
	logic                     done_q;
	logic [ERR_W-1:0]         err_q;

	logic signed [33:0]       mul_a;
	logic signed [33:0]       mul_b;
	logic [3:0]               rd_sel;
	logic signed [63:0]       sum_rd;
	logic                     acc_en;
	logic signed [63:0]       acc_term;
	logic [64:0]              acc_sum;
	logic signed [63:0]       acc_res;
	logic                     acc_ovf;
	logic                     sq_big;
	logic [63:0]              sq_t;
	logic                     sq_ge;
	logic [63:0]              res_next;
	logic [32:0]              div_t;
	logic                     div_ge;
	logic [32:0]              div_rem;
	logic [30:0]              q_next;
	logic signed [33:0]       dm;
	logic [1:0]               pb_idx;
	logic signed [31:0]       pb_pos;
	logic [63:0]              opb;
	logic [127:0]             wpp;
	logic [127:0]             wsgn;
	logic                     diag;

	assign pop          = (state_q == S_IDLE) && !qstat.empty;
	assign done         = done_q;
	assign error_value  = err_q;
	assign sample_count = cnt_q;
	assign saturated    = sat_q;

	// Square root step, one result bit per cycle.
	assign sq_t     = sq_res_q + sq_bit_q;
	assign sq_ge    = sumsq_q >= sq_t;
	assign res_next = sq_ge ? ((sq_res_q >> 1) + sq_bit_q) : (sq_res_q >> 1);

	// Restoring division step, one quotient bit per cycle.
	assign div_t   = {rem_q[31:0], numlo_q[30]};
	assign div_ge  = div_t >= {1'b0, root_q};
	assign div_rem = div_ge ? (div_t - {1'b0, root_q}) : div_t;
	assign q_next  = {quo_q[29:0], div_ge};

	assign dm     = dot_q[33] ? -dot_q : dot_q;
	assign pb_idx = 2'(idx_q - IDX_B0);
	assign pb_pos = pos_q[pb_idx];
	assign diag   = (idx_q == 4'd0) || (idx_q == 4'd3) || (idx_q == 4'd5);

	// Operand select of the shared multiplier.
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			S_SQ: begin
				mul_a = {2'b00, mag_q[idx_q[1:0]]};
				mul_b = {2'b00, mag_q[idx_q[1:0]]};
			end
			S_DOT: begin
				mul_a = 34'(u_q[idx_q[1:0]]);
				mul_b = 34'(pos_q[idx_q[1:0]]);
			end
			S_SQD: begin
				mul_a = dm;
				mul_b = dm;
			end
			S_AT: begin
				mul_a = 34'(u_q[pair_a(idx_q)]);
				mul_b = 34'(u_q[pair_b(idx_q)]);
			end
			S_BT: begin
				mul_a = dot_q;
				mul_b = 34'(u_q[idx_q[1:0]]);
			end
			S_EOP: begin
				mul_a = 34'(pos_q[pair_a(idx_q)]);
				mul_b = 34'(pos_q[pair_b(idx_q)]);
			end
			S_WMUL: begin
				mul_a = {2'b00, pp_q[1] ? ma_q[63:32] : ma_q[31:0]};
				mul_b = {2'b00, pp_q[0] ? mb_q[63:32] : mb_q[31:0]};
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// Read address of the sum registers.
	always_comb begin
		unique case (state_q)
			S_IDLE, S_SQD: rd_sel = IDX_C;
			S_BT:          rd_sel = IDX_B0 + idx_q;
			S_PT:          rd_sel = IDX_P0 + idx_q;
			default:       rd_sel = idx_q;
		endcase
	end
	assign sum_rd = sums_q[rd_sel];

	// Saturating accumulate into the selected sum.
	always_comb begin
		sq_big   = prod_q[63:0] > ACC_MAX_X[63:0];
		acc_term = term_q;
		acc_en   = 1'b0;
		unique case (state_q)
			S_SQD: begin
				acc_term = prod_q[63:0];
				acc_en   = (ph_q == 2'd1);
			end
			S_AT, S_BT: begin
				acc_en = (ph_q == 2'd2);
			end
			S_PT: begin
				acc_term = {{16{pos_q[idx_q[1:0]][31]}}, pos_q[idx_q[1:0]], 16'h0000};
				acc_en   = 1'b1;
			end
			default: begin
				acc_en = 1'b0;
			end
		endcase
		acc_sum = sat_add(sum_rd, acc_term);
		if (state_q == S_SQD && sq_big) begin
			acc_res = ACC_MAX_X[63:0];
			acc_ovf = 1'b1;
		end else begin
			acc_res = acc_sum[63:0];
			acc_ovf = acc_sum[64];
		end
	end

	// Wide multiply helpers: partial product placement and signed term.
	always_comb begin
		opb = (idx_q < IDX_B0) ? prod_q[63:0] : {{32{pb_pos[31]}}, pb_pos};
		unique case (pp_q)
			2'd0:    wpp = {64'd0, prod_q[63:0]};
			2'd3:    wpp = {prod_q[63:0], 64'd0};
			default: wpp = {32'd0, prod_q[63:0], 32'd0};
		endcase
		wsgn = wneg_q ? (~wprod_q + 128'd1) : wprod_q;
	end

	// The multiplier output is always registered.
	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
	end

	// Sequencer and datapath registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			idx_q   <= '0;
			ph_q    <= '0;
			it_q    <= '0;
			pp_q    <= '0;
			cnt_q   <= '0;
			sat_q   <= 1'b0;
			done_q  <= 1'b0;
			for (int i = 0; i < NUM_SUMS; i++) begin
				sums_q[i] <= '0;
			end
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (pop) begin
						idx_q <= '0;
						ph_q  <= '0;
						for (int i = 0; i < 3; i++) begin
							pos_q[i] <= head.pos[i];
							mag_q[i] <= head.mag[i];
						end
						neg_q <= head.neg;
						unique case (head.op)
							OP_ADD: begin
								sumsq_q <= '0;
								dacc_q  <= '0;
								if (head.nz) begin
									state_q <= S_NORM;
								end else begin
									for (int i = 0; i < 3; i++) begin
										u_q[i] <= '0;
									end
									state_q <= S_DOT;
								end
							end
							OP_EVAL: begin
								acc_q   <= {{64{sum_rd[63]}}, sum_rd};
								state_q <= S_EOP;
							end
							OP_CLEAR: begin
								for (int i = 0; i < NUM_SUMS; i++) begin
									sums_q[i] <= '0;
								end
								cnt_q  <= '0;
								sat_q  <= 1'b0;
								err_q  <= '0;
								done_q <= 1'b1;
							end
							OP_NOP: begin
								err_q  <= '0;
								done_q <= 1'b1;
							end
						endcase
					end
				end
				S_NORM: begin
					if (|(mag_q[0][31:30] | mag_q[1][31:30] | mag_q[2][31:30])) begin
						state_q <= S_SQ;
					end else begin
						for (int i = 0; i < 3; i++) begin
							mag_q[i] <= mag_q[i] << 1;
						end
					end
				end
				S_SQ: begin
					if (ph_q == 2'd0) begin
						ph_q <= 2'd1;
					end else begin
						sumsq_q <= sumsq_q + prod_q[63:0];
						ph_q    <= 2'd0;
						if (idx_q == 4'd2) begin
							sq_res_q <= '0;
							sq_bit_q <= 64'd1 << 62;
							it_q     <= '0;
							state_q  <= S_SQRT;
						end else begin
							idx_q <= idx_q + 4'd1;
						end
					end
				end
				S_SQRT: begin
					if (sq_ge) begin
						sumsq_q <= sumsq_q - sq_t;
					end
					sq_res_q <= res_next;
					sq_bit_q <= sq_bit_q >> 2;
					if (it_q == 5'd31) begin
						root_q  <= res_next[31:0];
						idx_q   <= '0;
						state_q <= S_DLD;
					end else begin
						it_q <= it_q + 5'd1;
					end
				end
				S_DLD: begin
					// The upper numerator bits are known to stay below the root.
					{rem_q, numlo_q} <= {2'b00, ({mag_q[idx_q[1:0]], 30'd0}
						+ {31'd0, root_q[31:1]})};
					quo_q   <= '0;
					it_q    <= '0;
					state_q <= S_DIV;
				end
				S_DIV: begin
					rem_q   <= div_rem;
					numlo_q <= numlo_q << 1;
					quo_q   <= q_next;
					if (it_q == 5'd30) begin
						u_q[idx_q[1:0]] <= neg_q[idx_q[1:0]] ? -$signed({1'b0, q_next})
							: $signed({1'b0, q_next});
						if (idx_q == 4'd2) begin
							idx_q   <= '0;
							ph_q    <= '0;
							state_q <= S_DOT;
						end else begin
							idx_q   <= idx_q + 4'd1;
							state_q <= S_DLD;
						end
					end else begin
						it_q <= it_q + 5'd1;
					end
				end
				S_DOT: begin
					if (ph_q == 2'd0) begin
						ph_q <= 2'd1;
					end else begin
						dacc_q <= dacc_q + prod_q[63:0];
						ph_q   <= 2'd0;
						if (idx_q == 4'd2) begin
							state_q <= S_RND;
						end else begin
							idx_q <= idx_q + 4'd1;
						end
					end
				end
				S_RND: begin
					dot_q   <= 34'(rnd_shift(dacc_q, 30));
					ph_q    <= '0;
					state_q <= S_SQD;
				end
				S_SQD: begin
					if (ph_q == 2'd0) begin
						ph_q <= 2'd1;
					end else begin
						ph_q    <= 2'd0;
						idx_q   <= '0;
						state_q <= S_AT;
					end
				end
				S_AT, S_BT: begin
					if (ph_q == 2'd0) begin
						ph_q <= 2'd1;
					end else if (ph_q == 2'd1) begin
						term_q <= (state_q == S_AT) ? rnd_shift(prod_q[63:0], 28)
							: rnd_shift(prod_q[63:0], 14);
						ph_q <= 2'd2;
					end else begin
						ph_q <= 2'd0;
						if (state_q == S_AT && idx_q == 4'd5) begin
							idx_q   <= '0;
							state_q <= S_BT;
						end else if (state_q == S_BT && idx_q == 4'd2) begin
							idx_q   <= '0;
							state_q <= S_PT;
						end else begin
							idx_q <= idx_q + 4'd1;
						end
					end
				end
				S_PT: begin
					if (idx_q == 4'd2) begin
						if (cnt_q != {CNT_W{1'b1}}) begin
							cnt_q <= cnt_q + 1'b1;
						end
						err_q   <= '0;
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						idx_q <= idx_q + 4'd1;
					end
				end
				S_EOP: begin
					if (ph_q == 2'd0) begin
						ph_q <= 2'd1;
					end else begin
						ma_q    <= mag64(sum_rd);
						mb_q    <= mag64(opb);
						wneg_q  <= sum_rd[63] ^ opb[63];
						wprod_q <= '0;
						pp_q    <= '0;
						ph_q    <= 2'd0;
						state_q <= S_WMUL;
					end
				end
				S_WMUL: begin
					if (ph_q == 2'd0) begin
						ph_q <= 2'd1;
					end else begin
						wprod_q <= wprod_q + wpp;
						ph_q    <= 2'd0;
						if (pp_q == 2'd3) begin
							state_q <= S_WF1;
						end else begin
							pp_q <= pp_q + 2'd1;
						end
					end
				end
				S_WF1: begin
					if (idx_q >= IDX_B0) begin
						wterm_q <= $signed(wsgn) >>> 15;
					end else if (diag) begin
						wterm_q <= $signed(wsgn) >>> 32;
					end else begin
						wterm_q <= $signed(wsgn) >>> 31;
					end
					state_q <= S_WF2;
				end
				S_WF2: begin
					acc_q <= (idx_q >= IDX_B0) ? (acc_q - wterm_q) : (acc_q + wterm_q);
					if (idx_q == 4'd8) begin
						state_q <= S_EFIN;
					end else begin
						idx_q   <= idx_q + 4'd1;
						ph_q    <= 2'd0;
						state_q <= S_EOP;
					end
				end
				S_EFIN: begin
					// Clamp the error to the unsigned 63-bit range.
					if (acc_q[127]) begin
						err_q <= '0;
					end else if (|acc_q[126:63]) begin
						err_q <= ERR_MAX;
					end else begin
						err_q <= acc_q[62:0];
					end
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
			if (acc_en) begin
				sums_q[rd_sel] <= acc_res;
				if (acc_ovf) begin
					sat_q <= 1'b1;
				end
			end
		end
	end

	`QEFA_ASSERT_IMP(a_div_rem, clk, arst_n, state_q == S_DIV, rem_q < {1'b0, root_q})
	`QEFA_ASSERT_IMP(a_norm_nz, clk, arst_n, state_q == S_NORM, |(mag_q[0] | mag_q[1] | mag_q[2]))
	`QEFA_ASSERT_IMP(a_done_idle, clk, arst_n, done_q, state_q == S_IDLE)

endmodule

// ===== rtl/qef_plane_accumulator_top.sv =====
// Top level of the QEF plane accumulator: front, request queue and back.
// Depends on qefa_pkg, qefa_front, qefa_queue and qefa_back.
//
//   channel   handshake        payload
//   request   start / busy     opcode, pos_x/y/z, norm_x/y/z
//   result    done (strobe)    error_value, sample_count, saturated
//
// In the back, an add request runs a 32-step square root, three 31-step divisions and
// up to 30 normalizing shifts; a zero normal skips them. An evaluate forms four partial
// products per wide multiply on the shared 34x34 multiplier. Clear and no-op finish
// straight from idle; the two-entry queue takes new requests while the back is busy.
// Reset zeroes all sums at once. The receiver cannot stall: each result is shown for
// one cycle under done, and busy is high only while the queue is full.
module qef_plane_accumulator_top import qefa_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	output logic                     busy,
	input  logic [1:0]               opcode,
	input  logic signed [DATA_W-1:0] pos_x,
	input  logic signed [DATA_W-1:0] pos_y,
	input  logic signed [DATA_W-1:0] pos_z,
	input  logic signed [DATA_W-1:0] norm_x,
	input  logic signed [DATA_W-1:0] norm_y,
	input  logic signed [DATA_W-1:0] norm_z,
	output logic                     done,
	output logic [ERR_W-1:0]         error_value,
	output logic [CNT_W-1:0]         sample_count,
	output logic                     saturated
);

	qefa_qstat_t qstat;
	qefa_entry_t wentry;
	qefa_entry_t head;
	logic        push;
	logic        pop;

	// Request intake and classification.
	qefa_front u_front (
		.start  (start),
		.busy   (busy),
		.opcode (opcode),
		.pos_x  (pos_x),
		.pos_y  (pos_y),
		.pos_z  (pos_z),
		.norm_x (norm_x),
		.norm_y (norm_y),
		.norm_z (norm_z),
		.qstat  (qstat),
		.push   (push),
		.entry  (wentry)
	);

	// Queue between the two sides.
	qefa_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (wentry),
		.pop    (pop),
		.rdata  (head),
		.qstat  (qstat)
	);

	// Execution sequencer and sum registers.
	qefa_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.qstat        (qstat),
		.head         (head),
		.pop          (pop),
		.done         (done),
		.error_value  (error_value),
		.sample_count (sample_count),
		.saturated    (saturated)
	);

endmodule

// ===== sim/tb_qef_plane_accumulator_top.sv =====
// Self-checking testbench of the QEF plane accumulator top level.
// Depends on qefa_pkg and qef_plane_accumulator_top; predicts every result
// from its own model of the sums and checks each one as it comes out.
module tb_qef_plane_accumulator_top;
	import qefa_pkg::*;

	// One request as the driver presents it.
	typedef struct {
		logic [1:0]               op;
		logic signed [DATA_W-1:0] pos [3];
		logic signed [DATA_W-1:0] nrm [3];
	} request_t;

	// One expected result.
	typedef struct {
		logic [ERR_W-1:0] err;
		logic [CNT_W-1:0] cnt;
		logic             sat;
	} qef_result_t;

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     start = 1'b0;
	logic                     busy;
	logic [1:0]               opcode = OP_NOP;
	logic signed [DATA_W-1:0] pos_x = '0, pos_y = '0, pos_z = '0;
	logic signed [DATA_W-1:0] norm_x = '0, norm_y = '0, norm_z = '0;
	logic                     done;
	logic [ERR_W-1:0]         error_value;
	logic [CNT_W-1:0]         sample_count;
	logic                     saturated;

	qef_plane_accumulator_top dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .opcode(opcode),
		.pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
		.norm_x(norm_x), .norm_y(norm_y), .norm_z(norm_z),
		.done(done), .error_value(error_value), .sample_count(sample_count),
		.saturated(saturated)
	);

	request_t    pending_requests[$];
	qef_result_t expected_results[$];
	logic        taken = 1'b0;
	int          gap = 0;
	int          errors = 0;
	int          n_add = 0, n_eval = 0, n_clear = 0, n_nop = 0;
	int          n_sat_seen = 0, n_err_clamped = 0, n_checked = 0;

	// Model state: Q32.32 sums, count and sticky saturation flag.
	logic signed [63:0] mat_sum [6];
	logic signed [63:0] vec_sum [3];
	logic signed [63:0] off_sum;
	logic signed [63:0] pos_sum [3];
	logic [CNT_W-1:0]   count_m;
	logic               sat_m;

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic void clear_sums();
		for (int i = 0; i < 6; i++) mat_sum[i] = '0;
		for (int i = 0; i < 3; i++) begin
			vec_sum[i] = '0;
			pos_sum[i] = '0;
		end
		off_sum = '0;
		count_m = '0;
		sat_m = 1'b0;
	endfunction

	// Divide by 2^k, rounding half away from zero.
	function automatic logic signed [63:0] round_shift(logic signed [63:0] v, int k);
		logic [63:0] mag;
		mag = v[63] ? -v : v;
		mag = (mag + (64'd1 << (k - 1))) >> k;
		return v[63] ? -$signed(mag) : $signed(mag);
	endfunction

	// Saturating add at the accumulator width; sets the sticky flag.
	function automatic logic signed [63:0] sum_sat(logic signed [63:0] a,
			logic signed [63:0] b);
		logic signed [64:0] s;
		s = 65'(a) + 65'(b);
		if (s > ACC_MAX_X) begin
			sat_m = 1'b1;
			return ACC_MAX_X[63:0];
		end
		if (s < ACC_MIN_X) begin
			sat_m = 1'b1;
			return ACC_MIN_X[63:0];
		end
		return s[63:0];
	endfunction

	function automatic logic [63:0] int_sqrt(logic [63:0] x);
		logic [63:0] res, bitv;
		res = '0;
		bitv = 64'd1 << 62;
		while (bitv > x) bitv = bitv >> 2;
		while (bitv != 0) begin
			if (x >= res + bitv) begin
				x = x - (res + bitv);
				res = (res >> 1) + bitv;
			end else begin
				res = res >> 1;
			end
			bitv = bitv >> 2;
		end
		return res;
	endfunction

	// Fold one point and normal into the sums.
	function automatic void add_plane(request_t r);
		logic signed [63:0] p [3];
		logic signed [63:0] u [3];
		logic [63:0]        m [3];
		logic [63:0]        mx, rt, q, dm, sq;
		logic               ng [3];
		logic signed [63:0] dot;
		int                 k;
		mx = '0;
		for (int i = 0; i < 3; i++) begin
			p[i] = r.pos[i];
			ng[i] = r.nrm[i][DATA_W-1];
			m[i] = ng[i] ? -64'(r.nrm[i]) : 64'(r.nrm[i]);
			u[i] = '0;
			if (m[i] > mx) mx = m[i];
		end
		if (mx != 0) begin
			while (mx < (64'd1 << 30)) begin
				mx = mx << 1;
				for (int i = 0; i < 3; i++) m[i] = m[i] << 1;
			end
			rt = int_sqrt(m[0] * m[0] + m[1] * m[1] + m[2] * m[2]);
			for (int i = 0; i < 3; i++) begin
				q = ((m[i] << 30) + (rt >> 1)) / rt;
				u[i] = ng[i] ? -$signed(q) : $signed(q);
			end
		end
		dot = round_shift(u[0] * p[0] + u[1] * p[1] + u[2] * p[2], 30);
		dm = dot[63] ? -dot : dot;
		sq = dm * dm;
		k = 0;
		for (int a = 0; a < 3; a++)
			for (int b = a; b < 3; b++) begin
				mat_sum[k] = sum_sat(mat_sum[k], round_shift(u[a] * u[b], 28));
				k++;
			end
		for (int i = 0; i < 3; i++) begin
			vec_sum[i] = sum_sat(vec_sum[i], round_shift(dot * u[i], 14));
			pos_sum[i] = sum_sat(pos_sum[i], p[i] <<< 16);
		end
		// A square beyond the signed limit pins the offset sum at once.
		if (sq > 64'(ACC_MAX_X)) begin
			sat_m = 1'b1;
			off_sum = ACC_MAX_X[63:0];
		end else begin
			off_sum = sum_sat(off_sum, $signed(sq));
		end
		if (count_m != '1) count_m++;
	endfunction

	// Error at a query position, clamped to the output range.
	function automatic logic [ERR_W-1:0] plane_error(request_t r);
		logic signed [127:0] acc, t;
		logic signed [63:0]  p [3];
		int                  k;
		for (int i = 0; i < 3; i++) p[i] = r.pos[i];
		acc = off_sum;
		k = 0;
		for (int a = 0; a < 3; a++)
			for (int b = a; b < 3; b++) begin
				t = 128'(mat_sum[k]) * 128'(p[a] * p[b]);
				acc = acc + (t >>> ((a == b) ? 32 : 31));
				k++;
			end
		for (int a = 0; a < 3; a++) begin
			t = 128'(vec_sum[a]) * 128'(p[a]);
			acc = acc - (t >>> 15);
		end
		if (acc < 0) return '0;
		if (acc > 128'(ERR_MAX)) return ERR_MAX;
		return acc[ERR_W-1:0];
	endfunction

	function automatic qef_result_t predict_result(request_t r);
		qef_result_t e;
		e.err = '0;
		case (r.op)
			OP_ADD: add_plane(r);
			OP_EVAL: e.err = plane_error(r);
			OP_CLEAR: clear_sums();
			default: ;
		endcase
		e.cnt = count_m;
		e.sat = sat_m;
		return e;
	endfunction

	task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
		$display("MISMATCH %s: got %0h, expected %0h at %0t", what, got, want, $realtime);
		errors++;
	endtask

	function automatic void push_request(logic [1:0] op, logic [31:0] px, logic [31:0] py,
			logic [31:0] pz, logic [31:0] nx, logic [31:0] ny, logic [31:0] nz);
		request_t r;
		r.op = op;
		r.pos[0] = px; r.pos[1] = py; r.pos[2] = pz;
		r.nrm[0] = nx; r.nrm[1] = ny; r.nrm[2] = nz;
		pending_requests.push_back(r);
	endfunction

	// Field value drawn from a mix of small, full-range and extreme values.
	function automatic logic [31:0] rand_field();
		int sel;
		sel = $urandom_range(0, 9);
		case (sel)
			0: return '0;
			1: return 32'h8000_0000;
			2: return 32'h7FFF_FFFF;
			3, 4: return $urandom();
			5: return $urandom_range(0, 3) - 2;
			default: return 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
		endcase
	endfunction

	function automatic int pick_gap();
		int sel;
		sel = $urandom_range(0, 99);
		if (sel < 55) return 0;
		if (sel < 93) return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	// Driver: holds a request until it is taken, then idles or presents the next.
	always @(negedge clk or negedge arst_n) begin : drive_requests
		request_t r;
		if (!arst_n) begin
			start <= 1'b0;
			gap <= 0;
		end else if (start && !taken) begin
		end else if (gap != 0) begin
			start <= 1'b0;
			gap <= gap - 1;
		end else if (pending_requests.size() != 0) begin
			r = pending_requests.pop_front();
			opcode <= r.op;
			pos_x <= r.pos[0]; pos_y <= r.pos[1]; pos_z <= r.pos[2];
			norm_x <= r.nrm[0]; norm_y <= r.nrm[1]; norm_z <= r.nrm[2];
			start <= 1'b1;
			gap <= pick_gap();
		end else begin
			start <= 1'b0;
		end
	end

	// Monitor: checks each result and predicts each request that is taken.
	always @(posedge clk) begin : watch_results
		qef_result_t e;
		request_t    r;
		taken <= arst_n && start && !busy;
		if (arst_n && done) begin
			n_checked++;
			if (saturated) n_sat_seen++;
			if (error_value == ERR_MAX) n_err_clamped++;
			if (expected_results.size() == 0) begin
				report_mismatch("unexpected result", error_value, 0);
			end else begin
				e = expected_results.pop_front();
				if (error_value !== e.err) report_mismatch("error_value", error_value, e.err);
				if (sample_count !== e.cnt)
					report_mismatch("sample_count", sample_count, e.cnt);
				if (saturated !== e.sat) report_mismatch("saturated", saturated, e.sat);
			end
		end
		if (arst_n && start && !busy) begin
			r.op = opcode;
			r.pos[0] = pos_x; r.pos[1] = pos_y; r.pos[2] = pos_z;
			r.nrm[0] = norm_x; r.nrm[1] = norm_y; r.nrm[2] = norm_z;
			case (opcode)
				OP_ADD: n_add++;
				OP_EVAL: n_eval++;
				OP_CLEAR: n_clear++;
				default: n_nop++;
			endcase
			expected_results.push_back(predict_result(r));
		end
	end

	// Stimulus and end of run.
	initial begin
		int sel;
		logic [1:0] op;
		clear_sums();
		// Directed part: empty sums, zero normal, axis and skew normals,
		// extreme fields, a no-op, clears, and an offset square that saturates.
		push_request(OP_EVAL, 32'h0001_0000, 32'hFFFF_0000, 0, 0, 0, 0);
		push_request(OP_ADD, 32'h0002_0000, 32'h0003_0000, 32'hFFFF_8000, 0, 0, 0);
		push_request(OP_ADD, 32'h0001_0000, 0, 0, 32'h0001_0000, 0, 0);
		push_request(OP_ADD, 0, 32'h0002_0000, 0, 0, 32'hFFFF_0000, 0);
		push_request(OP_ADD, 32'h0000_8000, 32'h0000_4000, 32'h0001_0000, 1, 1, 1);
		push_request(OP_EVAL, 32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 0, 0, 0);
		push_request(OP_NOP, 32'h7FFF_FFFF, 32'h8000_0000, 32'h1234_5678, 1, 2, 3);
		push_request(OP_ADD, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
			32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
		push_request(OP_EVAL, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0, 0, 0);
		push_request(OP_EVAL, 32'h7FFF_FFFF, 32'h8000_0000, 0, 0, 0, 0);
		push_request(OP_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
			32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		push_request(OP_ADD, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
			32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
		push_request(OP_ADD, 32'h8000_0000, 32'h7FFF_FFFF, 0, 32'h8000_0000, 32'h7FFF_FFFF, 0);
		push_request(OP_EVAL, 32'h0100_0000, 32'hFF00_0000, 32'h0000_0001, 0, 0, 0);
		push_request(OP_EVAL, 0, 0, 0, 0, 0, 0);
		push_request(OP_CLEAR, 0, 0, 0, 0, 0, 0);
		push_request(OP_ADD, 32'hFFFF_FFFF, 1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 32'h8000_0000);
		push_request(OP_EVAL, 32'hFFFF_FFFF, 1, 32'h7FFF_FFFF, 0, 0, 0);
		// Random part: mostly adds and evaluates, with clears and no-ops between.
		for (int i = 0; i < 550; i++) begin
			sel = $urandom_range(0, 99);
			op = (sel < 55) ? OP_ADD : (sel < 88) ? OP_EVAL : (sel < 93) ? OP_CLEAR : OP_NOP;
			push_request(op, rand_field(), rand_field(), rand_field(),
				rand_field(), rand_field(), rand_field());
		end
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		wait (pending_requests.size() == 0 && !start);
		wait (expected_results.size() == 0);
		repeat (400) @(posedge clk);
		$display("Covered %0d adds, %0d evaluates, %0d clears, %0d no-ops; %0d results checked.",
			n_add, n_eval, n_clear, n_nop, n_checked);
		$display("Results with the sticky flag set: %0d; error pinned at full scale: %0d.",
			n_sat_seen, n_err_clamped);
		if (errors == 0) begin
			$display("tb_qef_plane_accumulator_top: done, clean");
		end else begin
			$display("tb_qef_plane_accumulator_top: done, errors");
		end
		$finish;
	end

	// Watchdog far beyond the slowest correct run.
	initial begin
		#8000000;
		$display("Timeout with %0d results still expected.", expected_results.size());
		$display("tb_qef_plane_accumulator_top: done, errors");
		$finish;
	end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/qefa_pkg.sv
rtl/qefa_front.sv
rtl/qefa_queue.sv
rtl/qefa_back.sv
rtl/qef_plane_accumulator_top.sv
sim/tb_qef_plane_accumulator_top.sv
